>>> src/otac_pkg.sv
// Package for the obstacle-triggered actuator control block.
// Holds field widths, register indexes, reset values and action codes.
// Used by obstacle_triggered_actuator_control and its checker.
package otac_pkg;

	localparam int HISTORY_DEPTH_DEF = 5;

	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int LEAD_W   = 8;
	localparam int ACTION_W = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	localparam int CFG_ADDR_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_EXTEND_TIME = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SHORT_SPAN  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_SPAN   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SHORT_LEAD  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_LEAD   = 3'd5;

	// Register reset values.
	localparam logic [CFG_W-1:0]  COOLDOWN_RST    = 16'd2500;
	localparam logic [CFG_W-1:0]  EXTEND_TIME_RST = 16'd600;
	localparam logic [CFG_W-1:0]  SHORT_SPAN_RST  = 16'd150;
	localparam logic [CFG_W-1:0]  LONG_SPAN_RST   = 16'd350;
	localparam logic [LEAD_W-1:0] SHORT_LEAD_RST  = 8'd30;
	localparam logic [LEAD_W-1:0] LONG_LEAD_RST   = 8'd60;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_EXTEND  = 2'd1,
		ACT_RETRACT = 2'd2
	} action_t;

endpackage

>>> src/obstacle_triggered_actuator_control.sv
// Obstacle-triggered actuator control: top level, the whole datapath.
// Depends on otac_pkg.
//
// Each request on the s_ side is one poll tick and gives exactly one result on the m_ side.
// A tick is taken every clock cycle while the output register can take it: the decision,
// including the min and max search over the history ring, is made in the cycle of acceptance
// and is written into the output register as the tick is accepted. The output register is the
// only stage, so s_tready is low only while a result is held and m_tready is low. Configuration
// writes are always taken and should be made while no tick is in flight. The history ring and
// the cooldown state start cleared, with the actuator taken as already extended.
module obstacle_triggered_actuator_control #(
	parameter int HISTORY_DEPTH = otac_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Tick requests.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// From bit 0: left_hit, centre_hit, right_hit, now_ms[31:0], zero pad.
	input  logic [otac_pkg::IN_TDATA_W-1:0]   s_tdata,
	// Results.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// From bit 0: action[1:0], lead_ms[7:0], zero pad.
	output logic [otac_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [otac_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [otac_pkg::CFG_W-1:0]        cfg_data
);
	import otac_pkg::*;

	localparam int POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);

	// Configuration registers.
	logic [CFG_W-1:0]  cooldown_q;
	logic [CFG_W-1:0]  extend_time_q;
	logic [CFG_W-1:0]  short_span_q;
	logic [CFG_W-1:0]  long_span_q;
	logic [LEAD_W-1:0] short_lead_q;
	logic [LEAD_W-1:0] long_lead_q;

	// History and decision state.
	logic [HISTORY_DEPTH-1:0] ring_hit_q;
	logic [TIME_W-1:0]        ring_time_q [HISTORY_DEPTH];
	logic [POS_W-1:0]         ring_pos_q;
	logic                     is_extended_q;
	logic [TIME_W-1:0]        last_fire_q;

	// Output register.
	logic                out_vld_q;
	logic [ACTION_W-1:0] out_action_q;
	logic [LEAD_W-1:0]   out_lead_q;

	logic              accept;
	logic              left_hit, centre_hit, right_hit;
	logic [TIME_W-1:0] now_ms;

	logic              hit_any, hit_two;
	logic [TIME_W-1:0] lo_time, hi_time;
	logic [TIME_W-1:0] span;
	logic [LEAD_W-1:0] ring_lead;
	logic              cooled;
	action_t           action;
	logic [LEAD_W-1:0] lead;

	assign left_hit   = s_tdata[0];
	assign centre_hit = s_tdata[1];
	assign right_hit  = s_tdata[2];
	assign now_ms     = s_tdata[TIME_W+2:3];

	assign s_tready  = !out_vld_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Min and max over the ring as it stands after this tick is written.
	always_comb begin
		logic              h;
		logic [TIME_W-1:0] t;
		hit_any = 1'b0;
		hit_two = 1'b0;
		lo_time = '1;
		hi_time = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			h = (ring_pos_q == POS_W'(i)) ? centre_hit : ring_hit_q[i];
			t = (ring_pos_q == POS_W'(i)) ? now_ms : ring_time_q[i];
			if (h) begin
				hit_two = hit_two | hit_any;
				hit_any = 1'b1;
				if (t < lo_time) lo_time = t;
				if (t > hi_time) hi_time = t;
			end
		end
	end

	assign span = hi_time - lo_time;

	// The short threshold is tested first, even when the thresholds are out of order.
	always_comb begin
		if (!hit_two || span < {16'd0, short_span_q}) begin
			ring_lead = '0;
		end else if (span < {16'd0, long_span_q}) begin
			ring_lead = short_lead_q;
		end else begin
			ring_lead = long_lead_q;
		end
	end

	assign cooled = (now_ms - last_fire_q) > {16'd0, cooldown_q};

	always_comb begin
		action = ACT_NONE;
		lead   = '0;
		if (cooled) begin
			if (centre_hit || (left_hit && right_hit)) begin
				action = ACT_EXTEND;
				lead   = ring_lead;
			end else if (left_hit || right_hit) begin
				action = ACT_EXTEND;
			end else if (is_extended_q) begin
				action = ACT_RETRACT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q    <= COOLDOWN_RST;
			extend_time_q <= EXTEND_TIME_RST;
			short_span_q  <= SHORT_SPAN_RST;
			long_span_q   <= LONG_SPAN_RST;
			short_lead_q  <= SHORT_LEAD_RST;
			long_lead_q   <= LONG_LEAD_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_COOLDOWN:    cooldown_q    <= cfg_data;
				REG_EXTEND_TIME: extend_time_q <= cfg_data;
				REG_SHORT_SPAN:  short_span_q  <= cfg_data;
				REG_LONG_SPAN:   long_span_q   <= cfg_data;
				REG_SHORT_LEAD:  short_lead_q  <= cfg_data[LEAD_W-1:0];
				REG_LONG_LEAD:   long_lead_q   <= cfg_data[LEAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_hit_q    <= '0;
			ring_pos_q    <= '0;
			is_extended_q <= 1'b1;
			last_fire_q   <= '0;
		end else if (accept) begin
			ring_hit_q[ring_pos_q] <= centre_hit;
			ring_pos_q <= (ring_pos_q == POS_LAST) ? '0 : ring_pos_q + 1'b1;
			if (action == ACT_EXTEND) begin
				is_extended_q <= 1'b1;
				last_fire_q   <= now_ms + {24'd0, lead} + {16'd0, extend_time_q};
			end else if (action == ACT_RETRACT) begin
				is_extended_q <= 1'b0;
			end
		end
	end

	// Ring times are only read where the matching hit bit is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_time_q[ring_pos_q] <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s_tready) begin
			out_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_action_q <= action;
			out_lead_q   <= lead;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_lead_q, out_action_q};

endmodule

>>> src/otac_checker.sv
// Port-level checker for obstacle_triggered_actuator_control, with its bind.
// Depends on otac_pkg.
module otac_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [otac_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import otac_pkg::*;

	// A held result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every accepted tick shows a result in the next cycle.
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted tick gave no result");

	// An empty output register never blocks the input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] == ACT_NONE || m_tdata[1:0] == ACT_EXTEND
			|| m_tdata[1:0] == ACT_RETRACT)
		else $error("unknown action code");

	// A lead delay is only ever given with an extend.
	a_lead_extend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9:2] != 8'd0 |-> m_tdata[1:0] == ACT_EXTEND)
		else $error("lead delay without extend");

endmodule

bind obstacle_triggered_actuator_control otac_checker u_otac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/tb_obstacle_triggered_actuator_control.sv
`timescale 1ns / 1ps
// Self-checking bench for obstacle_triggered_actuator_control: a scoreboard class predicts
// each poll-tick decision and checks the result stream. Depends on otac_pkg and the block.

import otac_pkg::*;

class otac_scoreboard;
	typedef struct packed {
		action_t              action;
		logic [LEAD_W-1:0]    lead;
	} decision_t;

	logic [CFG_W-1:0]  cooldown;
	logic [CFG_W-1:0]  extend_time;
	logic [CFG_W-1:0]  short_span;
	logic [CFG_W-1:0]  long_span;
	logic [LEAD_W-1:0] short_lead;
	logic [LEAD_W-1:0] long_lead;

	bit                hist_hit [HISTORY_DEPTH_DEF];
	logic [TIME_W-1:0] hist_ms  [HISTORY_DEPTH_DEF];
	int unsigned       hist_pos;
	bit                extended;
	logic [TIME_W-1:0] last_fire;

	decision_t   decisions[$];
	int unsigned mismatches;

	function new();
		cooldown    = COOLDOWN_RST;
		extend_time = EXTEND_TIME_RST;
		short_span  = SHORT_SPAN_RST;
		long_span   = LONG_SPAN_RST;
		short_lead  = SHORT_LEAD_RST;
		long_lead   = LONG_LEAD_RST;
		foreach (hist_hit[i]) begin
			hist_hit[i] = 1'b0;
			hist_ms[i]  = '0;
		end
		hist_pos   = 0;
		extended   = 1'b1;
		last_fire  = '0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_COOLDOWN:    cooldown    = val;
			REG_EXTEND_TIME: extend_time = val;
			REG_SHORT_SPAN:  short_span  = val;
			REG_LONG_SPAN:   long_span   = val;
			REG_SHORT_LEAD:  short_lead  = val[LEAD_W-1:0];
			REG_LONG_LEAD:   long_lead   = val[LEAD_W-1:0];
			default: ;
		endcase
	endfunction

	// Span is taken over centre-hit entries only, as plain unsigned values.
	function logic [LEAD_W-1:0] lead_from_history();
		int unsigned       hits;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic [TIME_W-1:0] span;
		hits = 0;
		lo   = '1;
		hi   = '0;
		foreach (hist_hit[i]) begin
			if (hist_hit[i]) begin
				hits++;
				if (hist_ms[i] < lo) lo = hist_ms[i];
				if (hist_ms[i] > hi) hi = hist_ms[i];
			end
		end
		if (hits < 2) return '0;
		span = hi - lo;
		if (span < {16'd0, short_span}) return '0;
		if (span < {16'd0, long_span}) return short_lead;
		return long_lead;
	endfunction

	function void note_tick(bit left, bit centre, bit right, logic [TIME_W-1:0] tick_ms);
		decision_t         d;
		logic [TIME_W-1:0] elapsed;
		d.action = ACT_NONE;
		d.lead   = '0;
		hist_hit[hist_pos] = centre;
		hist_ms[hist_pos]  = tick_ms;
		hist_pos = (hist_pos + 1) % HISTORY_DEPTH_DEF;
		elapsed = tick_ms - last_fire;
		if (elapsed > {16'd0, cooldown}) begin
			if (centre || (left && right)) begin
				d.lead   = lead_from_history();
				d.action = ACT_EXTEND;
			end else if (left || right) begin
				d.action = ACT_EXTEND;
			end else if (extended) begin
				d.action = ACT_RETRACT;
			end
			if (d.action == ACT_EXTEND) begin
				extended  = 1'b1;
				last_fire = tick_ms + {24'd0, d.lead} + {16'd0, extend_time};
			end else if (d.action == ACT_RETRACT) begin
				extended = 1'b0;
			end
		end
		decisions.push_back(d);
	endfunction

	function void check_result(logic [OUT_TDATA_W-1:0] tdata);
		decision_t want;
		logic [ACTION_W-1:0] got_action;
		logic [LEAD_W-1:0]   got_lead;
		got_action = tdata[ACTION_W-1:0];
		got_lead   = tdata[ACTION_W +: LEAD_W];
		if (decisions.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t: result with no pending tick: action=%0d lead=%0d",
					$time, got_action, got_lead);
			return;
		end
		want = decisions.pop_front();
		if (got_action !== want.action || got_lead !== want.lead) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t: decision mismatch: action exp %0d got %0d, lead exp %0d got %0d",
					$time, want.action, got_action, want.lead, got_lead);
		end
	endfunction
endclass

module tb_obstacle_triggered_actuator_control;

	localparam int IDLE_LIMIT = 400;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_B = 3'd7;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_LONG
	} stall_mode_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	otac_scoreboard sb = new();

	int unsigned       burst_left = 0;
	int unsigned       idle_cycles = 0;
	logic [TIME_W-1:0] clock_ms = '0;

	stall_mode_t stall_mode = STALL_NONE;
	logic [7:0]  cyc_cnt    = '0;
	int unsigned stall_left = 0;

	obstacle_triggered_actuator_control uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure, in one of four stall patterns picked anew at random.
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1'b1;
		if (cyc_cnt[5:0] == 6'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:     m_tready <= 1'b1;
			STALL_COIN:     m_tready <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: m_tready <= (cyc_cnt[1:0] != 2'd3);
			default: begin
				if (stall_left != 0) begin
					stall_left <= stall_left - 1;
					m_tready   <= 1'b0;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left <= $urandom_range(1, 10);
				end
			end
		endcase
	end

	// Request monitor and watchdog. Results are checked before the tick of the same edge
	// is noted, since a tick can never produce its result in its own cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_tick(s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3 +: TIME_W]);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_addr, cfg_data);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_tick(bit left, bit centre, bit right, logic [TIME_W-1:0] tick_ms);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, tick_ms, right, centre, left};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_settings(logic [CFG_W-1:0] cool, logic [CFG_W-1:0] ext,
			logic [CFG_W-1:0] sspan, logic [CFG_W-1:0] lspan,
			logic [CFG_W-1:0] slead, logic [CFG_W-1:0] llead);
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_EXTEND_TIME, ext);
		write_reg(REG_SHORT_SPAN, sspan);
		write_reg(REG_LONG_SPAN, lspan);
		write_reg(REG_SHORT_LEAD, slead);
		write_reg(REG_LONG_LEAD, llead);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every expected decision has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.decisions.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Mostly monotonic timestamps with random detections, some jumps, noise and wraps.
	task automatic random_phase(int unsigned count, int unsigned step_max);
		int unsigned sel;
		bit l;
		bit c;
		bit r;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 80)
				clock_ms = clock_ms + $urandom_range(0, step_max);
			else if (sel < 88)
				clock_ms = clock_ms + $urandom_range(1000, 200000);
			else if (sel < 95)
				clock_ms = $urandom();
			else
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 3);
			if ($urandom_range(0, 3) == 0) begin
				l = 1'b0;
				c = 1'b0;
				r = 1'b0;
			end else begin
				c = ($urandom_range(0, 99) < 45);
				l = ($urandom_range(0, 2) == 0);
				r = ($urandom_range(0, 2) == 0);
			end
			send_tick(l, c, r, clock_ms);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: cooldown boundary, retract, side and centre extends, leads.
		send_tick(0, 0, 0, 32'd0);
		send_tick(0, 0, 0, 32'd2500);
		send_tick(0, 0, 0, 32'd2501);
		send_tick(0, 0, 0, 32'd2600);
		send_tick(1, 0, 0, 32'd2700);
		send_tick(0, 0, 1, 32'd5800);
		send_tick(0, 1, 0, 32'd5801);
		send_tick(0, 1, 0, 32'd6450);
		send_tick(0, 1, 0, 32'd8902);
		send_tick(1, 0, 1, 32'd12063);
		// Flush the history so only a medium span remains, then fire for the short lead.
		send_tick(0, 0, 0, 32'd15000);
		send_tick(0, 0, 0, 32'd15010);
		send_tick(0, 0, 0, 32'd15020);
		send_tick(0, 1, 0, 32'd15030);
		send_tick(0, 1, 0, 32'd15100);
		send_tick(0, 0, 0, 32'd15150);
		send_tick(0, 1, 0, 32'd15230);
		// Timestamp wrap: the fire time wraps past zero and the span ignores the wrap.
		send_tick(1, 1, 1, 32'hFFFF_FF00);
		send_tick(0, 0, 0, 32'hFFFF_FFFF);
		send_tick(0, 1, 0, 32'h0000_0A00);
		drain();

		clock_ms = 32'd1000;
		write_settings(16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)),
			16'($urandom_range(20, 60)), 16'($urandom_range(80, 200)),
			16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
		random_phase(76, 40);
		drain();

		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF);
		random_phase(76, 30000);
		drain();

		write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_phase(76, 50);
		drain();

		// Thresholds out of order: the short one is tested first.
		write_settings(16'd100, 16'd50, 16'd300, 16'd100, 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255)));
		random_phase(76, 120);
		drain();

		// Unused indexes must leave every register alone.
		write_reg(REG_COOLDOWN, 16'($urandom()));
		write_reg(REG_EXTEND_TIME, 16'($urandom()));
		write_reg(REG_SHORT_SPAN, 16'($urandom()));
		write_reg(REG_LONG_SPAN, 16'($urandom()));
		write_reg(REG_SHORT_LEAD, 16'($urandom()));
		write_reg(REG_LONG_LEAD, 16'($urandom()));
		write_reg(REG_UNUSED_A, 16'($urandom()));
		write_reg(REG_UNUSED_B, 16'($urandom()));
		cfg_valid <= 1'b0;
		random_phase(76, 5000);
		drain();

		write_settings(16'd1, 16'd0, 16'($urandom_range(0, 100)), 16'($urandom_range(50, 300)),
			16'd0, 16'hFFFF);
		random_phase(76, 80);
		drain();

		write_settings(COOLDOWN_RST, EXTEND_TIME_RST, SHORT_SPAN_RST, LONG_SPAN_RST,
			{8'd0, SHORT_LEAD_RST}, {8'd0, LONG_LEAD_RST});
		random_phase(76, 700);
		drain();

		if (sb.mismatches == 0 && sb.decisions.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
